>>> rtl/csvt_pkg.sv
package csvt_pkg;

  localparam int FIELD_LEN_BITS_DEF   = 16;
  localparam int FIELD_INDEX_BITS_DEF = 8;

  localparam logic [7:0] DELIM_RST = 8'd44;
  localparam logic [7:0] QUOTE_RST = 8'd34;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    EV_DATA      = 3'd0,
    EV_FIELD_END = 3'd1,
    EV_LINE_END  = 3'd2,
    EV_FINISH    = 3'd3,
    EV_ERROR     = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_BAD_QUOTE    = 2'd1,
    ERR_UNTERMINATED = 2'd2
  } error_code_t;

  typedef enum logic {
    OP_TEXT = 1'b0,
    OP_END  = 1'b1
  } operation_t;

  typedef enum logic {
    REG_DELIMITER = 1'b0,
    REG_QUOTE     = 1'b1
  } reg_index_t;

  typedef enum logic [5:0] {
    PH_START    = 6'b000001,
    PH_PLAIN    = 6'b000010,
    PH_PLAIN_CR = 6'b000100,
    PH_QUOTED   = 6'b001000,
    PH_QSEEN    = 6'b010000,
    PH_QCR      = 6'b100000
  } phase_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data_byte;
    logic [7:0]  field_index;
    logic [15:0] field_length;
    logic        was_quoted;
    error_code_t error_code;
    logic        last;
  } result_t;

  typedef struct packed {
    result_t    r0;
    result_t    r1;
    logic [1:0] count;
  } result_pair_t;

  function automatic result_t res_data(input logic [7:0] b);
    result_t r;
    r           = '0;
    r.kind      = EV_DATA;
    r.data_byte = b;
    return r;
  endfunction

  function automatic result_t res_end(input logic line, input logic [7:0] idx,
                                      input logic [15:0] len, input logic q);
    result_t r;
    r              = '0;
    r.kind         = line ? EV_LINE_END : EV_FIELD_END;
    r.field_index  = idx;
    r.field_length = len;
    r.was_quoted   = q;
    return r;
  endfunction

  function automatic result_t res_error(input error_code_t code);
    result_t r;
    r            = '0;
    r.kind       = EV_ERROR;
    r.error_code = code;
    return r;
  endfunction

  function automatic result_t res_finish();
    result_t r;
    r      = '0;
    r.kind = EV_FINISH;
    return r;
  endfunction

endpackage

>>> rtl/csvt_cfg.sv
module csvt_cfg
  import csvt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [7:0]               delim,
  output logic [7:0]               quote
);

  logic [7:0] delim_r;
  logic [7:0] quote_r;
  logic       wr_en;
  reg_index_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign sel    = reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RST;
      quote_r <= QUOTE_RST;
    end else if (wr_en) begin
      unique case (sel)
        REG_DELIMITER: delim_r <= pwdata[7:0];
        REG_QUOTE:     quote_r <= pwdata[7:0];
        default:       delim_r <= delim_r;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DELIMITER: prdata = CFG_DATA_BITS'(delim_r);
      REG_QUOTE:     prdata = CFG_DATA_BITS'(quote_r);
      default:       prdata = '0;
    endcase
  end

  assign delim = delim_r;
  assign quote = quote_r;

endmodule

>>> rtl/csvt_step.sv
module csvt_step
  import csvt_pkg::*;
#(
  parameter int FIELD_LEN_BITS   = FIELD_LEN_BITS_DEF,
  parameter int FIELD_INDEX_BITS = FIELD_INDEX_BITS_DEF
) (
  input  phase_t                      phase,
  input  logic [FIELD_INDEX_BITS-1:0] idx,
  input  logic [FIELD_LEN_BITS-1:0]   len,
  input  logic                        quoted,
  input  error_code_t                 err,
  input  operation_t                  op,
  input  logic [7:0]                  b,
  input  logic [7:0]                  delim,
  input  logic [7:0]                  quote,
  output phase_t                      phase_nxt,
  output logic [FIELD_INDEX_BITS-1:0] idx_nxt,
  output logic [FIELD_LEN_BITS-1:0]   len_nxt,
  output logic                        quoted_nxt,
  output error_code_t                 err_nxt,
  output result_pair_t                res
);

  logic [FIELD_LEN_BITS:0]     sum1;
  logic [FIELD_LEN_BITS:0]     sum2;
  logic [FIELD_LEN_BITS-1:0]   len_p1;
  logic [FIELD_LEN_BITS-1:0]   len_p2;
  logic [FIELD_INDEX_BITS-1:0] idx_inc;
  logic [31:0]                 len_w;
  logic [31:0]                 len_p1_w;
  logic [15:0]                 idx_w;
  logic [15:0]                 len16;
  logic [15:0]                 len16_p1;
  logic [7:0]                  idx8;
  result_t                     r0;
  result_t                     r1;
  logic [1:0]                  cnt;

  assign sum1   = {1'b0, len} + {{FIELD_LEN_BITS{1'b0}}, 1'b1};
  assign sum2   = {1'b0, len} + {{(FIELD_LEN_BITS-1){1'b0}}, 2'b10};
  assign len_p1 = sum1[FIELD_LEN_BITS] ? '1 : sum1[FIELD_LEN_BITS-1:0];
  assign len_p2 = sum2[FIELD_LEN_BITS] ? '1 : sum2[FIELD_LEN_BITS-1:0];

  assign idx_inc = (idx == '1) ? idx : idx + {{(FIELD_INDEX_BITS-1){1'b0}}, 1'b1};

  assign len_w    = 32'(len);
  assign len_p1_w = 32'(len_p1);
  assign idx_w    = 16'(idx);
  assign len16    = len_w[15:0];
  assign len16_p1 = len_p1_w[15:0];
  assign idx8     = idx_w[7:0];

  always_comb begin
    phase_nxt  = phase;
    idx_nxt    = idx;
    len_nxt    = len;
    quoted_nxt = quoted;
    err_nxt    = err;
    r0         = '0;
    r1         = '0;
    cnt        = 2'd0;

    if (err != ERR_NONE) begin
      r0  = res_error(err);
      cnt = 2'd1;
    end else if (op == OP_END) begin
      cnt = 2'd1;
      if (phase == PH_START) begin
        r0         = res_finish();
        idx_nxt    = '0;
        len_nxt    = '0;
        quoted_nxt = 1'b0;
      end else begin
        r0      = res_error(ERR_UNTERMINATED);
        err_nxt = ERR_UNTERMINATED;
      end
    end else begin
      unique case (phase)
        PH_START, PH_PLAIN: begin
          if (phase == PH_START && b == quote) begin
            quoted_nxt = 1'b1;
            phase_nxt  = PH_QUOTED;
          end else if (b == delim) begin
            r0         = res_end(1'b0, idx8, len16, quoted);
            cnt        = 2'd1;
            idx_nxt    = idx_inc;
            len_nxt    = '0;
            quoted_nxt = 1'b0;
            phase_nxt  = PH_START;
          end else if (b == CH_CR) begin
            phase_nxt = PH_PLAIN_CR;
          end else begin
            r0        = res_data(b);
            cnt       = 2'd1;
            len_nxt   = len_p1;
            phase_nxt = PH_PLAIN;
          end
        end
        PH_PLAIN_CR: begin
          if (b == CH_LF) begin
            r0         = res_end(1'b1, idx8, len16, quoted);
            cnt        = 2'd1;
            idx_nxt    = '0;
            len_nxt    = '0;
            quoted_nxt = 1'b0;
            phase_nxt  = PH_START;
          end else begin
            r0 = res_data(CH_CR);
            if (b == delim) begin
              r1         = res_end(1'b0, idx8, len16_p1, quoted);
              cnt        = 2'd2;
              idx_nxt    = idx_inc;
              len_nxt    = '0;
              quoted_nxt = 1'b0;
              phase_nxt  = PH_START;
            end else if (b == CH_CR) begin
              cnt       = 2'd1;
              len_nxt   = len_p1;
              phase_nxt = PH_PLAIN_CR;
            end else begin
              r1        = res_data(b);
              cnt       = 2'd2;
              len_nxt   = len_p2;
              phase_nxt = PH_PLAIN;
            end
          end
        end
        PH_QUOTED: begin
          if (b == quote) begin
            phase_nxt = PH_QSEEN;
          end else begin
            r0      = res_data(b);
            cnt     = 2'd1;
            len_nxt = len_p1;
          end
        end
        PH_QSEEN: begin
          if (b == quote) begin
            r0        = res_data(b);
            cnt       = 2'd1;
            len_nxt   = len_p2;
            phase_nxt = PH_QUOTED;
          end else if (b == delim) begin
            r0         = res_end(1'b0, idx8, len16, quoted);
            cnt        = 2'd1;
            idx_nxt    = idx_inc;
            len_nxt    = '0;
            quoted_nxt = 1'b0;
            phase_nxt  = PH_START;
          end else if (b == CH_CR) begin
            phase_nxt = PH_QCR;
          end else begin
            r0      = res_error(ERR_BAD_QUOTE);
            cnt     = 2'd1;
            err_nxt = ERR_BAD_QUOTE;
          end
        end
        PH_QCR: begin
          cnt = 2'd1;
          if (b == CH_LF) begin
            r0         = res_end(1'b1, idx8, len16, quoted);
            idx_nxt    = '0;
            len_nxt    = '0;
            quoted_nxt = 1'b0;
            phase_nxt  = PH_START;
          end else begin
            r0      = res_error(ERR_BAD_QUOTE);
            err_nxt = ERR_BAD_QUOTE;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end

    if (cnt == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign res.r0    = r0;
  assign res.r1    = r1;
  assign res.count = cnt;

endmodule

>>> rtl/csvt_outq.sv
module csvt_outq
  import csvt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  result_pair_t push,
  input  logic         pop_ready,
  output result_t      head,
  output logic         head_valid,
  output logic         room
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  result_t             mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [PTR_BITS:0]   cnt_r;
  logic [PTR_BITS:0]   cnt_nxt;
  logic                pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid & pop_ready;
  assign room       = (cnt_r <= (PTR_BITS+1)'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PTR_BITS'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + PTR_BITS'(pop);
  assign cnt_nxt    = cnt_r + (PTR_BITS+1)'(push.count) - (PTR_BITS+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + PTR_BITS'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/csv_field_tokenizer.sv
// Each accepted item writes its results into a registered 4-entry result queue.
// Throughput: one item per cycle while the queue holds at most two entries; an
// item that gives two results puts both in the queue, and the output shows them in turn.
// Reset (rst_n low, synchronous): parser returns to field start, counters and
// sticky error clear, registers return to comma and double quote, queue empties.
module csv_field_tokenizer
  import csvt_pkg::*;
#(
  parameter int FIELD_LEN_BITS   = FIELD_LEN_BITS_DEF,
  parameter int FIELD_INDEX_BITS = FIELD_INDEX_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // data_byte[7:0]
  input  logic [0:0]               in_tuser,   // operation[0]
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [39:0]              out_tdata,  // out_byte[7:0], field_index[15:8],
                                               // field_length[31:16], was_quoted[32],
                                               // error_code[34:33], zero[39:35]
  output logic [2:0]               out_tuser,  // event_kind[2:0]
  output logic                     out_tlast,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  phase_t                      phase_r;
  phase_t                      phase_nxt;
  logic [FIELD_INDEX_BITS-1:0] idx_r;
  logic [FIELD_INDEX_BITS-1:0] idx_nxt;
  logic [FIELD_LEN_BITS-1:0]   len_r;
  logic [FIELD_LEN_BITS-1:0]   len_nxt;
  logic                        quoted_r;
  logic                        quoted_nxt;
  error_code_t                 err_r;
  error_code_t                 err_nxt;
  logic [7:0]                  delim;
  logic [7:0]                  quote;
  result_pair_t                step_res;
  result_pair_t                push;
  result_t                     head;
  logic                        room;
  logic                        accept;

  csvt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .delim   (delim),
    .quote   (quote)
  );

  csvt_step #(
    .FIELD_LEN_BITS   (FIELD_LEN_BITS),
    .FIELD_INDEX_BITS (FIELD_INDEX_BITS)
  ) u_step (
    .phase      (phase_r),
    .idx        (idx_r),
    .len        (len_r),
    .quoted     (quoted_r),
    .err        (err_r),
    .op         (operation_t'(in_tuser[0])),
    .b          (in_tdata),
    .delim      (delim),
    .quote      (quote),
    .phase_nxt  (phase_nxt),
    .idx_nxt    (idx_nxt),
    .len_nxt    (len_nxt),
    .quoted_nxt (quoted_nxt),
    .err_nxt    (err_nxt),
    .res        (step_res)
  );

  assign in_tready = room;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    push = step_res;
    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      idx_r    <= '0;
      len_r    <= '0;
      quoted_r <= 1'b0;
      err_r    <= ERR_NONE;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      len_r    <= len_nxt;
      quoted_r <= quoted_nxt;
      err_r    <= err_nxt;
    end
  end

  csvt_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  assign out_tdata = {5'b0, head.error_code, head.was_quoted, head.field_length,
                      head.field_index, head.data_byte};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> rtl/csvt_checker.sv
module csvt_checker
  import csvt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == EV_ERROR) == (out_tdata[34:33] != ERR_NONE)))
    else $error("error code does not match event kind");

  a_data_only_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_DATA |-> out_tdata[7:0] == 8'd0 && out_tlast)
    else $error("non-data event carries a byte or is not last");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == EV_ERROR |=>
      !out_tvalid || out_tuser == EV_ERROR)
    else $error("result after an error is not an error");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

>>> tb/tb_csv_field_tokenizer.sv
module tb_csv_field_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import csvt_pkg::*;

  localparam int LEN_MAX     = (1 << FIELD_LEN_BITS_DEF) - 1;
  localparam int IDX_MAX     = (1 << FIELD_INDEX_BITS_DEF) - 1;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 60;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 200;

  // -1 picks a random register value
  localparam int PHASE_DELIM[NUM_PHASES] = '{44, 44, 0, 255, 39, 13, -1, 9};
  localparam int PHASE_QUOTE[NUM_PHASES] = '{34, 34, 255, 0, 39, 34, -1, 39};
  localparam int PHASE_SEND_IDLE[NUM_PHASES] = '{0, 60, 0, 36, 60, 0, 36, 0};
  localparam int PHASE_RECV_STALL[NUM_PHASES] = '{0, 0, 60, 36, 0, 60, 36, 0};

  typedef enum logic [2:0] {
    FS_START,
    FS_PLAIN,
    FS_PLAIN_CR,
    FS_QUOTED,
    FS_QUOTE_SEEN,
    FS_QUOTE_CR
  } field_state_t;

  typedef struct {
    field_state_t phase;
    int           fidx;
    int           flen;
    bit           quoted;
    error_code_t  err;
    logic [7:0]   delim;
    logic [7:0]   quote;
  } tok_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  obyte;
    logic [7:0]  fidx;
    logic [15:0] flen;
    logic        quoted;
    error_code_t err;
    logic        last;
  } token_t;

  typedef token_t [1:0] token_pair_t;

  typedef struct {
    operation_t op;
    logic [7:0] b;
    int         nres;
    token_t     tok;
  } script_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [7:0]               in_tdata = '0;
  logic [0:0]               in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [39:0]              out_tdata;
  logic [2:0]               out_tuser;
  logic                     out_tlast;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  tok_state_t  st;
  token_t      expected_tokens[$];
  script_row_t script_rows[$];
  int          send_idle = 0;
  int          recv_stall = 0;
  int          fails = 0;
  int          prints = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;

  csv_field_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void tok_put(inout token_pair_t r, inout int n, input event_kind_t k,
                                  input logic [7:0] ob, input int fidx, input int flen,
                                  input bit q, input error_code_t e);
    token_t t;
    t        = '0;
    t.kind   = k;
    t.obyte  = ob;
    t.fidx   = fidx[7:0];
    t.flen   = flen[15:0];
    t.quoted = q;
    t.err    = e;
    r[n]     = t;
    n++;
  endfunction

  function automatic void tok_data(inout tok_state_t s, inout token_pair_t r, inout int n,
                                   input logic [7:0] b, input int w);
    tok_put(r, n, EV_DATA, b, 0, 0, 1'b0, ERR_NONE);
    s.flen = (s.flen + w > LEN_MAX) ? LEN_MAX : s.flen + w;
  endfunction

  function automatic void tok_end(inout tok_state_t s, inout token_pair_t r, inout int n,
                                  input bit line);
    tok_put(r, n, line ? EV_LINE_END : EV_FIELD_END, 8'd0, s.fidx, s.flen, s.quoted,
            ERR_NONE);
    if (line) begin
      s.fidx = 0;
    end else if (s.fidx < IDX_MAX) begin
      s.fidx++;
    end
    s.flen   = 0;
    s.quoted = 1'b0;
    s.phase  = FS_START;
  endfunction

  function automatic void tok_fail(inout tok_state_t s, inout token_pair_t r, inout int n,
                                   input error_code_t e);
    s.err = e;
    tok_put(r, n, EV_ERROR, 8'd0, 0, 0, 1'b0, e);
  endfunction

  function automatic void tok_plain(inout tok_state_t s, inout token_pair_t r, inout int n,
                                    input logic [7:0] b);
    if (b == s.delim) begin
      tok_end(s, r, n, 1'b0);
    end else if (b == CH_CR) begin
      s.phase = FS_PLAIN_CR;
    end else begin
      tok_data(s, r, n, b, 1);
      s.phase = FS_PLAIN;
    end
  endfunction

  function automatic int tok_step(inout tok_state_t s, input operation_t op,
                                  input logic [7:0] b, output token_pair_t r);
    int n;
    n = 0;
    r = '0;
    if (s.err != ERR_NONE) begin
      tok_put(r, n, EV_ERROR, 8'd0, 0, 0, 1'b0, s.err);
    end else if (op == OP_END) begin
      if (s.phase == FS_START) begin
        tok_put(r, n, EV_FINISH, 8'd0, 0, 0, 1'b0, ERR_NONE);
        s.fidx   = 0;
        s.flen   = 0;
        s.quoted = 1'b0;
      end else begin
        tok_fail(s, r, n, ERR_UNTERMINATED);
      end
    end else begin
      case (s.phase)
        FS_START: begin
          if (b == s.quote) begin
            s.quoted = 1'b1;
            s.phase  = FS_QUOTED;
          end else begin
            tok_plain(s, r, n, b);
          end
        end
        FS_PLAIN: tok_plain(s, r, n, b);
        FS_PLAIN_CR: begin
          if (b == CH_LF) begin
            tok_end(s, r, n, 1'b1);
          end else begin
            tok_data(s, r, n, CH_CR, 1);
            tok_plain(s, r, n, b);
          end
        end
        FS_QUOTED: begin
          if (b == s.quote) s.phase = FS_QUOTE_SEEN;
          else tok_data(s, r, n, b, 1);
        end
        FS_QUOTE_SEEN: begin
          if (b == s.quote) begin
            tok_data(s, r, n, b, 2);
            s.phase = FS_QUOTED;
          end else if (b == s.delim) begin
            tok_end(s, r, n, 1'b0);
          end else if (b == CH_CR) begin
            s.phase = FS_QUOTE_CR;
          end else begin
            tok_fail(s, r, n, ERR_BAD_QUOTE);
          end
        end
        FS_QUOTE_CR: begin
          if (b == CH_LF) tok_end(s, r, n, 1'b1);
          else tok_fail(s, r, n, ERR_BAD_QUOTE);
        end
        default: s.phase = FS_START;
      endcase
    end
    if (n > 0) r[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_row(input operation_t op, input logic [7:0] b,
                                  input int nres = -1, input event_kind_t kind = EV_DATA,
                                  input logic [7:0] obyte = 8'd0,
                                  input logic [7:0] fidx = 8'd0,
                                  input logic [15:0] flen = 16'd0, input bit q = 1'b0,
                                  input error_code_t err = ERR_NONE);
    script_row_t row;
    row.op         = op;
    row.b          = b;
    row.nres       = nres;
    row.tok        = '0;
    row.tok.kind   = kind;
    row.tok.obyte  = obyte;
    row.tok.fidx   = fidx;
    row.tok.flen   = flen;
    row.tok.quoted = q;
    row.tok.err    = err;
    row.tok.last   = 1'b1;
    script_rows.push_back(row);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return st.delim;
      1:       return st.quote;
      2:       return CH_CR;
      3:       return CH_LF;
      4, 5:    return 8'($urandom_range(255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic report(input string what, input longint e, input longint a);
    fails++;
    if (prints < PRINT_CAP) begin
      prints++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, e, a);
    end
  endtask

  task automatic drive_item(input operation_t op, input logic [7:0] b);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic predict_and_queue(input operation_t op, input logic [7:0] b);
    token_pair_t r;
    int          n;
    n = tok_step(st, op, b, r);
    for (int k = 0; k < n; k++) expected_tokens.push_back(r[k]);
  endtask

  // steer away from anything that would latch the sticky error
  task automatic send_item(input operation_t op, input logic [7:0] b);
    tok_state_t  probe;
    token_pair_t r;
    int          n;
    probe = st;
    n     = tok_step(probe, op, b, r);
    if (probe.err != ERR_NONE) begin
      op = OP_TEXT;
      b  = (st.phase == FS_QUOTE_CR) ? CH_LF : st.delim;
    end
    drive_item(op, b);
    predict_and_queue(op, b);
  endtask

  task automatic run_script();
    token_pair_t r;
    foreach (script_rows[i]) begin
      drive_item(script_rows[i].op, script_rows[i].b);
      if (script_rows[i].nres < 0) begin
        predict_and_queue(script_rows[i].op, script_rows[i].b);
      end else begin
        void'(tok_step(st, script_rows[i].op, script_rows[i].b, r));
        if (script_rows[i].nres == 1) expected_tokens.push_back(script_rows[i].tok);
      end
    end
    script_rows.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [7:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_BITS'(4 * int'(idx));
    cfg_pwdata  <= CFG_DATA_BITS'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== v) report("register readback", v, cfg_prdata[7:0]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_DELIMITER) st.delim = v;
    else st.quote = v;
  endtask

  task automatic send_record();
    int         nf;
    int         len;
    logic [7:0] b;
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) send_item(OP_TEXT, st.delim);
      len = $urandom_range(0, 6);
      if ($urandom_range(1) == 1) begin
        send_item(OP_TEXT, st.quote);
        for (int i = 0; i < len; i++) begin
          b = pick_byte();
          send_item(OP_TEXT, b);
          if (b == st.quote) send_item(OP_TEXT, b);
        end
        send_item(OP_TEXT, st.quote);
      end else begin
        for (int i = 0; i < len; i++) begin
          b = pick_byte();
          if (i == 0 && b == st.quote) b = b ^ 8'h01;
          send_item(OP_TEXT, b);
        end
      end
    end
    send_item(OP_TEXT, CH_CR);
    send_item(OP_TEXT, CH_LF);
    if ($urandom_range(7) == 0) send_item(OP_END, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(15) == 0) send_item(OP_END, 8'($urandom_range(255)));
      else if ($urandom_range(1) == 1) send_item(OP_TEXT, 8'($urandom_range(255)));
      else send_item(OP_TEXT, pick_byte());
    end
  endtask

  always @(posedge clk) begin
    token_t exp_tok;
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        report("result with nothing outstanding, kind", -1, out_tuser);
      end else begin
        exp_tok = expected_tokens.pop_front();
        results_checked++;
        if (out_tuser !== exp_tok.kind) report("event kind", exp_tok.kind, out_tuser);
        if (out_tdata[7:0] !== exp_tok.obyte)
          report("data byte", exp_tok.obyte, out_tdata[7:0]);
        if (out_tdata[15:8] !== exp_tok.fidx)
          report("field index", exp_tok.fidx, out_tdata[15:8]);
        if (out_tdata[31:16] !== exp_tok.flen)
          report("field length", exp_tok.flen, out_tdata[31:16]);
        if (out_tdata[32] !== exp_tok.quoted)
          report("quoted flag", exp_tok.quoted, out_tdata[32]);
        if (out_tdata[34:33] !== exp_tok.err)
          report("error code", exp_tok.err, out_tdata[34:33]);
        if (out_tlast !== exp_tok.last) report("last flag", exp_tok.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_psel || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t ns: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [7:0]  d;
    logic [7:0]  q;
    error_code_t code;

    st.phase  = FS_START;
    st.fidx   = 0;
    st.flen   = 0;
    st.quoted = 1'b0;
    st.err    = ERR_NONE;
    st.delim  = DELIM_RST;
    st.quote  = QUOTE_RST;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_END, 8'hFF, 1, EV_FINISH);
    add_row(OP_TEXT, QUOTE_RST, 0);
    add_row(OP_TEXT, 8'hFF, 1, EV_DATA, 8'hFF);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, DELIM_RST, 1, EV_FIELD_END, 8'd0, 8'd0, 16'd3, 1'b1);
    add_row(OP_TEXT, 8'h00, 1, EV_DATA, 8'h00);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, CH_CR);
    add_row(OP_TEXT, 8'h41);
    add_row(OP_TEXT, CH_CR);
    add_row(OP_TEXT, CH_LF, 1, EV_LINE_END, 8'd0, 8'd1, 16'd4, 1'b0);
    add_row(OP_TEXT, DELIM_RST, 1, EV_FIELD_END, 8'd0, 8'd0, 16'd0, 1'b0);
    add_row(OP_TEXT, CH_CR);
    add_row(OP_TEXT, CH_LF, 1, EV_LINE_END, 8'd0, 8'd1, 16'd0, 1'b0);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, CH_CR);
    add_row(OP_TEXT, QUOTE_RST);
    add_row(OP_TEXT, CH_CR);
    add_row(OP_TEXT, CH_LF, 1, EV_LINE_END, 8'd0, 8'd0, 16'd1, 1'b1);
    add_row(OP_TEXT, 8'h61);
    add_row(OP_TEXT, DELIM_RST, 1, EV_FIELD_END, 8'd0, 8'd0, 16'd1, 1'b0);
    add_row(OP_END, 8'h00, 1, EV_FINISH);
    add_row(OP_END, 8'h5A, 1, EV_FINISH);
    run_script();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      d = (PHASE_DELIM[p] < 0) ? 8'($urandom_range(255)) : 8'(PHASE_DELIM[p]);
      q = (PHASE_QUOTE[p] < 0) ? 8'($urandom_range(255)) : 8'(PHASE_QUOTE[p]);
      cfg_write(REG_DELIMITER, d);
      cfg_write(REG_QUOTE, q);
      settings_used++;
      send_idle  = PHASE_SEND_IDLE[p];
      recv_stall = PHASE_RECV_STALL[p];
      while (items_sent < 25 + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) send_record();
        else send_noise();
      end
    end

    // drive the field index into saturation
    wait_drained();
    send_idle  = 0;
    recv_stall = 0;
    while (st.phase != FS_START) begin
      case (st.phase)
        FS_PLAIN_CR, FS_QUOTE_CR: send_item(OP_TEXT, CH_LF);
        FS_QUOTED:                send_item(OP_TEXT, st.quote);
        default:                  send_item(OP_TEXT, st.delim);
      endcase
    end
    repeat (IDX_MAX + 5) send_item(OP_TEXT, st.delim);
    send_item(OP_TEXT, CH_CR);
    send_item(OP_TEXT, CH_LF);

    wait_drained();
    cfg_write(REG_DELIMITER, DELIM_RST);
    cfg_write(REG_QUOTE, QUOTE_RST);
    settings_used++;
    send_idle  = 36;
    recv_stall = 36;
    while (st.phase != FS_START) begin
      case (st.phase)
        FS_PLAIN_CR, FS_QUOTE_CR: send_item(OP_TEXT, CH_LF);
        FS_QUOTED:                send_item(OP_TEXT, st.quote);
        default:                  send_item(OP_TEXT, st.delim);
      endcase
    end

    code = ($urandom_range(1) == 1) ? ERR_BAD_QUOTE : ERR_UNTERMINATED;
    if (code == ERR_BAD_QUOTE) begin
      add_row(OP_TEXT, QUOTE_RST, 0);
      add_row(OP_TEXT, 8'($urandom_range(8'h61, 8'h7A)));
      add_row(OP_TEXT, QUOTE_RST, 0);
      add_row(OP_TEXT, 8'($urandom_range(8'h61, 8'h7A)), 1, EV_ERROR, 8'd0, 8'd0, 16'd0,
              1'b0, ERR_BAD_QUOTE);
    end else begin
      add_row(OP_TEXT, 8'($urandom_range(8'h61, 8'h7A)));
      add_row(OP_END, 8'($urandom_range(255)), 1, EV_ERROR, 8'd0, 8'd0, 16'd0, 1'b0,
              ERR_UNTERMINATED);
    end
    repeat (6) begin
      add_row(operation_t'($urandom_range(1)), 8'($urandom_range(255)), 1, EV_ERROR, 8'd0,
              8'd0, 16'd0, 1'b0, code);
    end
    run_script();

    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d input items and %0d checked results over %0d register settings,",
             items_sent, results_checked, settings_used);
    $display("with the field index driven to saturation and a closing sticky error of code %0d.",
             code);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
